>>> hdl/json_hello_version_checker_unit_defines.svh
// Assertion helpers for the RTL
`ifndef JSON_HELLO_VERSION_CHECKER_UNIT_DEFINES_SVH
`define JSON_HELLO_VERSION_CHECKER_UNIT_DEFINES_SVH

// Clocked assertion, masked while reset is asserted
`define JHV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define JHV_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/jhv_pkg.sv
package jhv_pkg;

	// parser phases
	typedef enum logic [4:0] {
		PH_LEAD, PH_KEY, PH_KSTR, PH_KESC, PH_KHEX, PH_COLON, PH_VALSTART,
		PH_VER, PH_AFTER_TOP, PH_TRAIL,
		PH_SVAL, PH_OBJ_FIRST, PH_OBJ_KEY, PH_SCOLON, PH_ARR_FIRST, PH_SAFTER,
		PH_SSTR, PH_SESC, PH_SHEX,
		PH_LTRUE, PH_LFALSE, PH_LNULL,
		PH_NNEG, PH_NZERO, PH_NINT, PH_NDOT, PH_NFRAC, PH_NEXP, PH_NESIGN,
		PH_NEDIG
	} phase_t;

	// parser state without the nesting stack
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  sub;
		logic [3:0]  kmp;
		logic [1:0]  alive;
		logic [63:0] acc;
		logic [1:0]  seen;
		logic [63:0] minv;
		logic [63:0] maxv;
	} pst_t;

	// nesting stack request from one parse pass
	typedef struct packed {
		logic push;
		logic kind;
		logic pop;
	} stk_op_t;

	localparam int KEY_LEN = 10;
	localparam int OUT_W   = 136;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic is_esc(input logic [7:0] c);
		return c == CH_QUOTE || c == CH_BSL || c == "/" || c == "b" || c == "f" ||
			c == "n" || c == "r" || c == "t";
	endfunction

	// letters of minVersion / maxVersion
	function automatic logic [7:0] key_char(input logic [3:0] idx, input logic is_max);
		logic [7:0] ch;
		unique case (idx)
			4'd0: ch = "m";
			4'd1: ch = is_max ? "a" : "i";
			4'd2: ch = is_max ? "x" : "n";
			4'd3: ch = "V";
			4'd4: ch = "e";
			4'd5: ch = "r";
			4'd6: ch = "s";
			4'd7: ch = "i";
			4'd8: ch = "o";
			4'd9: ch = "n";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// letters of true / false / null
	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		unique case (k)
			2'd0: begin
				unique case (idx)
					3'd0: ch = "t"; 3'd1: ch = "r"; 3'd2: ch = "u"; 3'd3: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			2'd1: begin
				unique case (idx)
					3'd0: ch = "f"; 3'd1: ch = "a"; 3'd2: ch = "l"; 3'd3: ch = "s";
					3'd4: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			2'd2: begin
				unique case (idx)
					3'd0: ch = "n"; 3'd1: ch = "u"; 3'd2: ch = "l"; 3'd3: ch = "l";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] k);
		return (k == 2'd1) ? 3'd5 : 3'd4;
	endfunction

endpackage

>>> hdl/jhv_step.sv
module jhv_step (
	input  jhv_pkg::pst_t    cur,
	input  logic [7:0]       c,
	input  logic             lvl_zero,
	input  logic             lvl_one,
	input  logic             lvl_full,
	input  logic             top_kind,
	output jhv_pkg::pst_t    nxt,
	output logic             consumed,
	output logic             fail,
	output jhv_pkg::stk_op_t op
);
	import jhv_pkg::*;

	logic [7:0]  ka_c;
	logic [3:0]  ka_kmp;
	logic [1:0]  ka_alive;
	logic [1:0]  lk;
	logic [3:0]  dig;
	logic [67:0] acc10;
	phase_t      vdone;
	phase_t      pdone;

	// key letter accumulation, '?' stands in for a \u escape
	always_comb begin
		ka_c     = (cur.phase == PH_KHEX) ? CH_QMARK : c;
		ka_kmp   = 4'd11;
		ka_alive = 2'b00;
		if (cur.kmp < 4'(KEY_LEN)) begin
			ka_alive = cur.alive;
			if (ka_c != key_char(cur.kmp, 1'b0)) ka_alive[0] = 1'b0;
			if (ka_c != key_char(cur.kmp, 1'b1)) ka_alive[1] = 1'b0;
			ka_kmp = cur.kmp + 4'd1;
		end
	end

	// decimal accumulate: acc * 10 + digit, overflow shows in the top bits
	assign dig   = c[3:0] - CH_ZERO[3:0];
	assign acc10 = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1) + 68'(dig);

	assign lk    = (cur.phase == PH_LTRUE) ? 2'd0 : (cur.phase == PH_LFALSE) ? 2'd1 : 2'd2;
	assign vdone = lvl_zero ? PH_AFTER_TOP : PH_SAFTER;
	assign pdone = (lvl_zero || lvl_one) ? PH_AFTER_TOP : PH_SAFTER;

	// one pass over the byte
	always_comb begin
		nxt      = cur;
		consumed = 1'b1;
		fail     = 1'b0;
		op       = '0;
		unique case (cur.phase)
			PH_LEAD: begin
				if (is_ws(c)) ;
				else if (c == CH_LBRC) nxt.phase = PH_KEY;
				else fail = 1'b1;
			end
			PH_KEY: begin
				if (is_ws(c)) ;
				else if (c == CH_QUOTE) begin
					nxt.phase = PH_KSTR;
					nxt.kmp   = 4'd0;
					nxt.alive = 2'b11;
				end else fail = 1'b1;
			end
			PH_KSTR: begin
				if (c == CH_QUOTE) begin
					if (cur.kmp != 4'(KEY_LEN)) nxt.alive = 2'b00;
					nxt.phase = PH_COLON;
				end else if (c < CH_SPACE) fail = 1'b1;
				else if (c == CH_BSL) nxt.phase = PH_KESC;
				else begin
					nxt.kmp   = ka_kmp;
					nxt.alive = ka_alive;
				end
			end
			PH_KESC: begin
				if (c == "u") begin
					nxt.phase = PH_KHEX;
					nxt.sub   = 3'd0;
				end else if (is_esc(c)) begin
					nxt.kmp   = ka_kmp;
					nxt.alive = ka_alive;
					nxt.phase = PH_KSTR;
				end else fail = 1'b1;
			end
			PH_KHEX: begin
				if (!is_hex(c)) fail = 1'b1;
				else if (cur.sub >= 3'd3) begin
					nxt.sub   = 3'd0;
					nxt.kmp   = ka_kmp;
					nxt.alive = ka_alive;
					nxt.phase = PH_KSTR;
				end else nxt.sub = cur.sub + 3'd1;
			end
			PH_COLON: begin
				if (is_ws(c)) ;
				else if (c == CH_COLON) nxt.phase = PH_VALSTART;
				else fail = 1'b1;
			end
			PH_VALSTART: begin
				if (is_ws(c)) ;
				else if (cur.alive != 2'b00) begin
					if (!is_digit(c)) fail = 1'b1;
					else begin
						nxt.acc   = 64'(dig);
						nxt.phase = PH_VER;
					end
				end else begin
					nxt.phase = PH_SVAL;
					consumed  = 1'b0;
				end
			end
			PH_VER: begin
				if (is_digit(c)) begin
					if (|acc10[67:64]) fail = 1'b1;
					else nxt.acc = acc10[63:0];
				end else if ((cur.seen & cur.alive) != 2'b00) fail = 1'b1;
				else begin
					if (cur.alive == 2'b01) nxt.minv = cur.acc;
					else nxt.maxv = cur.acc;
					nxt.seen  = cur.seen | cur.alive;
					nxt.phase = PH_AFTER_TOP;
					consumed  = 1'b0;
				end
			end
			PH_AFTER_TOP: begin
				if (is_ws(c)) ;
				else if (c == CH_RBRC) nxt.phase = PH_TRAIL;
				else if (c == CH_COMMA) nxt.phase = PH_KEY;
				else fail = 1'b1;
			end
			PH_TRAIL: begin
				if (!is_ws(c)) fail = 1'b1;
			end
			PH_SVAL: begin
				if (is_ws(c)) ;
				else if (lvl_full) fail = 1'b1;
				else if (c == CH_QUOTE) begin
					nxt.phase = PH_SSTR;
					nxt.sub   = 3'd0;
				end else if (c == CH_LBRC || c == CH_LBRK) begin
					op.push   = 1'b1;
					op.kind   = (c == CH_LBRC);
					nxt.phase = (c == CH_LBRC) ? PH_OBJ_FIRST : PH_ARR_FIRST;
				end else if (c == "t") begin
					nxt.phase = PH_LTRUE;
					nxt.sub   = 3'd1;
				end else if (c == "f") begin
					nxt.phase = PH_LFALSE;
					nxt.sub   = 3'd1;
				end else if (c == "n") begin
					nxt.phase = PH_LNULL;
					nxt.sub   = 3'd1;
				end else if (c == CH_MINUS) nxt.phase = PH_NNEG;
				else if (c == CH_ZERO) nxt.phase = PH_NZERO;
				else if (is_digit(c)) nxt.phase = PH_NINT;
				else fail = 1'b1;
			end
			PH_OBJ_FIRST, PH_OBJ_KEY: begin
				if (is_ws(c)) ;
				else if (c == CH_RBRC && cur.phase == PH_OBJ_FIRST) begin
					op.pop    = 1'b1;
					nxt.phase = pdone;
				end else if (c == CH_QUOTE) begin
					nxt.phase = PH_SSTR;
					nxt.sub   = 3'd4;
				end else fail = 1'b1;
			end
			PH_SCOLON: begin
				if (is_ws(c)) ;
				else if (c == CH_COLON) nxt.phase = PH_SVAL;
				else fail = 1'b1;
			end
			PH_ARR_FIRST: begin
				if (is_ws(c)) ;
				else if (c == CH_RBRK) begin
					op.pop    = 1'b1;
					nxt.phase = pdone;
				end else begin
					nxt.phase = PH_SVAL;
					consumed  = 1'b0;
				end
			end
			PH_SAFTER: begin
				if (is_ws(c)) ;
				else if (lvl_zero) fail = 1'b1;
				else if (c == CH_COMMA) nxt.phase = top_kind ? PH_OBJ_KEY : PH_SVAL;
				else if ((top_kind && c == CH_RBRC) || (!top_kind && c == CH_RBRK)) begin
					op.pop    = 1'b1;
					nxt.phase = pdone;
				end else fail = 1'b1;
			end
			PH_SSTR: begin
				if (c == CH_QUOTE) nxt.phase = cur.sub[2] ? PH_SCOLON : vdone;
				else if (c < CH_SPACE) fail = 1'b1;
				else if (c == CH_BSL) nxt.phase = PH_SESC;
			end
			PH_SESC: begin
				if (c == "u") begin
					nxt.phase = PH_SHEX;
					nxt.sub   = {cur.sub[2], 2'b00};
				end else if (is_esc(c)) nxt.phase = PH_SSTR;
				else fail = 1'b1;
			end
			PH_SHEX: begin
				if (!is_hex(c)) fail = 1'b1;
				else if (cur.sub[1:0] == 2'b11) begin
					nxt.sub   = {cur.sub[2], 2'b00};
					nxt.phase = PH_SSTR;
				end else nxt.sub = cur.sub + 3'd1;
			end
			PH_LTRUE, PH_LFALSE, PH_LNULL: begin
				if (cur.sub >= lit_len(lk)) fail = 1'b1;
				else if (c != lit_char(lk, cur.sub)) fail = 1'b1;
				else begin
					nxt.sub = cur.sub + 3'd1;
					if (cur.sub + 3'd1 == lit_len(lk)) nxt.phase = vdone;
				end
			end
			PH_NNEG: begin
				if (c == CH_ZERO) nxt.phase = PH_NZERO;
				else if (is_digit(c)) nxt.phase = PH_NINT;
				else fail = 1'b1;
			end
			PH_NZERO, PH_NINT, PH_NFRAC: begin
				if (is_digit(c) && cur.phase != PH_NZERO) ;
				else if (c == CH_DOT && cur.phase != PH_NFRAC) nxt.phase = PH_NDOT;
				else if (c == "e" || c == "E") nxt.phase = PH_NEXP;
				else begin
					nxt.phase = vdone;
					consumed  = 1'b0;
				end
			end
			PH_NDOT: begin
				if (is_digit(c)) nxt.phase = PH_NFRAC;
				else fail = 1'b1;
			end
			PH_NEXP: begin
				if (c == CH_PLUS || c == CH_MINUS) nxt.phase = PH_NESIGN;
				else if (is_digit(c)) nxt.phase = PH_NEDIG;
				else fail = 1'b1;
			end
			PH_NESIGN: begin
				if (is_digit(c)) nxt.phase = PH_NEDIG;
				else fail = 1'b1;
			end
			PH_NEDIG: begin
				if (is_digit(c)) ;
				else begin
					nxt.phase = vdone;
					consumed  = 1'b0;
				end
			end
			default: fail = 1'b1;
		endcase
	end

endmodule

>>> hdl/json_hello_version_checker_unit.sv
// Streaming checker for a JSON hello message carrying minVersion/maxVersion.
// Input channel s_*: one message byte per word, s_tlast on the final byte.
// Output channel m_*: one word per message, produced for the word with
// s_tlast set: accept flag plus both decoded 64-bit versions (zero when
// the message is rejected).
// Throughput: one byte per cycle while s_tready is high. Each byte is parsed by up to two chained
// passes of the same next-state logic in the cycle it is accepted.
// Latency: the result word is valid the cycle after the last byte is taken.
// s_tready is low only while a result word is held and m_tready is low; the
// output register lets a new byte in the same cycle the held word leaves.
// Reset clears the parser to "expect whitespace or '{'" and drops any
// pending result word. After each message the parser returns to that state.
// The nesting stack is a row of MAX_DEPTH flops, one per level.
module json_hello_version_checker_unit #(
	parameter int MAX_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] data_byte
	input  logic                       s_tlast,   // last_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [jhv_pkg::OUT_W-1:0]  m_tdata    // [0] accepted, [64:1] lowest version,
	                                              // [128:65] highest version, rest zero
);
	import jhv_pkg::*;

	`include "json_hello_version_checker_unit_defines.svh"

	localparam int LVL_W = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	pst_t                 st_q;
	logic                 failed_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [MAX_DEPTH-1:0] stk_q;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	logic             s_fire;
	logic             lvl_zero, lvl_one, lvl_full, top_kind;
	logic [LVL_W-1:0] lvl_m1;
	pst_t             n1, n2, nsel;
	logic             c1, c2, f1, f2, fsel;
	stk_op_t          op1, op2, osel;
	logic             fail_new, ok;

	assign s_fire   = s_tvalid && s_tready;
	assign s_tready = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// nesting level decode
	assign lvl_zero = (lvl_q == '0);
	assign lvl_one  = (lvl_q == LVL_W'(1));
	assign lvl_full = (lvl_q == LVL_W'(MAX_DEPTH));
	assign lvl_m1   = lvl_q - LVL_W'(1);
	assign top_kind = lvl_zero ? 1'b0 : stk_q[lvl_m1[IDX_W-1:0]];

	// first pass, and a second one for a byte the first pass hands on
	jhv_step u_pass1 (
		.cur(st_q), .c(s_tdata), .lvl_zero(lvl_zero), .lvl_one(lvl_one),
		.lvl_full(lvl_full), .top_kind(top_kind),
		.nxt(n1), .consumed(c1), .fail(f1), .op(op1)
	);

	jhv_step u_pass2 (
		.cur(n1), .c(s_tdata), .lvl_zero(lvl_zero), .lvl_one(lvl_one),
		.lvl_full(lvl_full), .top_kind(top_kind),
		.nxt(n2), .consumed(c2), .fail(f2), .op(op2)
	);

	assign nsel     = c1 ? n1 : n2;
	assign fsel     = c1 ? f1 : (f2 || !c2);
	assign osel     = c1 ? op1 : op2;
	assign fail_new = failed_q || fsel;
	assign ok       = !fail_new && nsel.phase == PH_TRAIL && nsel.seen == 2'b11 &&
		nsel.minv <= nsel.maxv;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '{phase: PH_LEAD, alive: 2'b11, default: '0};
			failed_q   <= 1'b0;
			lvl_q      <= '0;
			stk_q      <= '0;
		end else if (s_fire) begin
			if (s_tlast) begin
				st_q     <= '{phase: PH_LEAD, alive: 2'b11, default: '0};
				failed_q <= 1'b0;
				lvl_q    <= '0;
				stk_q    <= '0;
			end else if (!failed_q) begin
				st_q     <= nsel;
				failed_q <= fsel;
				if (!fsel && osel.push) begin
					stk_q[lvl_q[IDX_W-1:0]] <= osel.kind;
					lvl_q                   <= lvl_q + LVL_W'(1);
				end else if (!fsel && osel.pop && !lvl_zero) begin
					lvl_q <= lvl_m1;
				end
			end
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_fire && s_tlast) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && s_tlast) begin
			m_tdata_q <= {7'b0, ok ? nsel.maxv : 64'd0, ok ? nsel.minv : 64'd0, ok};
		end
	end

	`JHV_ASSERT(a_rise_after_last, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast), "result word without a last byte")
	`JHV_ASSERT(a_range_ok, (m_tvalid && m_tdata[0]) |-> (m_tdata[64:1] <= m_tdata[128:65]), "accepted with min above max")
	`JHV_ASSERT(a_reject_zero, (m_tvalid && !m_tdata[0]) |-> (m_tdata[128:1] == '0), "rejected word carries versions")
	`JHV_ASSERT(a_depth, lvl_q <= LVL_W'(MAX_DEPTH), "nesting level beyond limit")

endmodule

>>> sim/jhv_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the verdict of each message and compares.
module jhv_checker #(
	parameter int MAX_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [7:0]                s_tdata,   // [7:0] data_byte
	input  logic                      s_tlast,   // last_byte
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [jhv_pkg::OUT_W-1:0] m_tdata,   // [0] accepted, [64:1] min, [128:65] max
	output int                        fail_count,
	output int                        pending,
	output int                        verdicts_seen,
	output int                        accepts_seen
);
	import jhv_pkg::*;

	typedef struct {
		logic        ok;
		logic [63:0] lo;
		logic [63:0] hi;
	} verdict_t;

	verdict_t verdict_q[$];

	// predictor state
	phase_t      ph;
	logic        kinds[MAX_DEPTH];
	int unsigned lvl;
	int unsigned subp;
	int unsigned kpos;
	logic [1:0]  live;
	logic [63:0] num;
	logic [63:0] vmin;
	logic [63:0] vmax;
	logic [1:0]  seen;
	logic        bad;

	function automatic logic ws(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction
	function automatic logic dig(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction
	function automatic logic hexc(logic [7:0] c);
		return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction
	function automatic logic escc(logic [7:0] c);
		return c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
			c == "n" || c == "r" || c == "t";
	endfunction

	task automatic clear_parser();
		ph = PH_LEAD;
		for (int i = 0; i < MAX_DEPTH; i++) kinds[i] = 1'b0;
		lvl = 0; subp = 0; kpos = 0; live = 2'b11;
		num = '0; vmin = '0; vmax = '0; seen = '0; bad = 1'b0;
	endtask

	task automatic key_letter(logic [7:0] c);
		string wmin, wmax;
		wmin = "minVersion";
		wmax = "maxVersion";
		if (kpos < 10) begin
			if (c != wmin[kpos]) live[0] = 1'b0;
			if (c != wmax[kpos]) live[1] = 1'b0;
			kpos++;
		end else begin
			kpos = 11;
			live = 2'b00;
		end
	endtask

	task automatic end_value();
		ph = (lvl == 0) ? PH_AFTER_TOP : PH_SAFTER;
	endtask

	task automatic close_level();
		if (lvl > 0) lvl--;
		end_value();
	endtask

	// one parse pass; consumed is 0 when the byte must be looked at again
	task automatic parse_pass(logic [7:0] c, output logic consumed);
		string lit;
		logic [63:0] d;
		logic k;
		logic fail;
		consumed = 1'b1;
		fail = 1'b0;
		case (ph)
			PH_LEAD: begin
				if (c == "{") ph = PH_KEY;
				else if (!ws(c)) fail = 1;
			end
			PH_KEY: begin
				if (c == "\"") begin
					ph = PH_KSTR; kpos = 0; live = 2'b11;
				end else if (!ws(c)) fail = 1;
			end
			PH_KSTR: begin
				if (c == "\"") begin
					if (kpos != 10) live = 2'b00;
					ph = PH_COLON;
				end else if (c < 8'h20) fail = 1;
				else if (c == "\\") ph = PH_KESC;
				else key_letter(c);
			end
			PH_KESC: begin
				if (c == "u") begin
					ph = PH_KHEX; subp = 0;
				end else if (escc(c)) begin
					key_letter(c); ph = PH_KSTR;
				end else fail = 1;
			end
			PH_KHEX: begin
				if (!hexc(c)) fail = 1;
				else if (subp >= 3) begin
					subp = 0; key_letter("?"); ph = PH_KSTR;
				end else subp++;
			end
			PH_COLON: begin
				if (c == ":") ph = PH_VALSTART;
				else if (!ws(c)) fail = 1;
			end
			PH_VALSTART: begin
				if (ws(c)) ;
				else if (live != 0) begin
					if (!dig(c)) fail = 1;
					else begin
						num = 64'(c - 8'h30); ph = PH_VER;
					end
				end else begin
					ph = PH_SVAL; consumed = 0;
				end
			end
			PH_VER: begin
				if (dig(c)) begin
					d = 64'(c - 8'h30);
					if (num > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) fail = 1;
					else num = num * 10 + d;
				end else if ((seen & live) != 0) fail = 1;
				else begin
					if (live == 2'b01) vmin = num; else vmax = num;
					seen |= live;
					ph = PH_AFTER_TOP; consumed = 0;
				end
			end
			PH_AFTER_TOP: begin
				if (c == "}") ph = PH_TRAIL;
				else if (c == ",") ph = PH_KEY;
				else if (!ws(c)) fail = 1;
			end
			PH_TRAIL: if (!ws(c)) fail = 1;
			PH_SVAL: begin
				if (ws(c)) ;
				else if (lvl + 1 > MAX_DEPTH) fail = 1;
				else if (c == "\"") begin
					ph = PH_SSTR; subp = 0;
				end else if (c == "{" || c == "[") begin
					kinds[lvl] = (c == "{");
					lvl++;
					ph = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
				end else if (c == "t") begin
					ph = PH_LTRUE; subp = 1;
				end else if (c == "f") begin
					ph = PH_LFALSE; subp = 1;
				end else if (c == "n") begin
					ph = PH_LNULL; subp = 1;
				end else if (c == "-") ph = PH_NNEG;
				else if (c == "0") ph = PH_NZERO;
				else if (dig(c)) ph = PH_NINT;
				else fail = 1;
			end
			PH_OBJ_FIRST, PH_OBJ_KEY: begin
				if (ws(c)) ;
				else if (c == "}" && ph == PH_OBJ_FIRST) close_level();
				else if (c == "\"") begin
					ph = PH_SSTR; subp = 4;
				end else fail = 1;
			end
			PH_SCOLON: begin
				if (c == ":") ph = PH_SVAL;
				else if (!ws(c)) fail = 1;
			end
			PH_ARR_FIRST: begin
				if (ws(c)) ;
				else if (c == "]") close_level();
				else begin
					ph = PH_SVAL; consumed = 0;
				end
			end
			PH_SAFTER: begin
				if (ws(c)) ;
				else if (lvl == 0) fail = 1;
				else begin
					k = kinds[lvl-1];
					if (c == ",") ph = k ? PH_OBJ_KEY : PH_SVAL;
					else if ((k && c == "}") || (!k && c == "]")) close_level();
					else fail = 1;
				end
			end
			PH_SSTR: begin
				if (c == "\"") begin
					if (subp & 4) ph = PH_SCOLON; else end_value();
				end else if (c < 8'h20) fail = 1;
				else if (c == "\\") ph = PH_SESC;
			end
			PH_SESC: begin
				if (c == "u") begin
					ph = PH_SHEX; subp &= 4;
				end else if (escc(c)) ph = PH_SSTR;
				else fail = 1;
			end
			PH_SHEX: begin
				if (!hexc(c)) fail = 1;
				else if ((subp & 3) == 3) begin
					subp &= 4; ph = PH_SSTR;
				end else subp++;
			end
			PH_LTRUE, PH_LFALSE, PH_LNULL: begin
				lit = (ph == PH_LTRUE) ? "true" : (ph == PH_LFALSE) ? "false" : "null";
				if (subp >= lit.len() || c != lit[subp]) fail = 1;
				else begin
					subp++;
					if (subp == lit.len()) end_value();
				end
			end
			PH_NNEG: begin
				if (c == "0") ph = PH_NZERO;
				else if (dig(c)) ph = PH_NINT;
				else fail = 1;
			end
			PH_NZERO, PH_NINT, PH_NFRAC: begin
				if (dig(c) && ph != PH_NZERO) ;
				else if (c == "." && ph != PH_NFRAC) ph = PH_NDOT;
				else if (c == "e" || c == "E") ph = PH_NEXP;
				else begin
					end_value(); consumed = 0;
				end
			end
			PH_NDOT: if (dig(c)) ph = PH_NFRAC; else fail = 1;
			PH_NEXP: begin
				if (c == "+" || c == "-") ph = PH_NESIGN;
				else if (dig(c)) ph = PH_NEDIG;
				else fail = 1;
			end
			PH_NESIGN: if (dig(c)) ph = PH_NEDIG; else fail = 1;
			PH_NEDIG: begin
				if (!dig(c)) begin
					end_value(); consumed = 0;
				end
			end
			default: fail = 1;
		endcase
		if (fail) begin
			bad = 1'b1; consumed = 1'b1;
		end
	endtask

	task automatic predict_byte(logic [7:0] c, logic last);
		logic took;
		verdict_t v;
		if (!bad) begin
			for (int i = 0; i < 4 && !bad; i++) begin
				parse_pass(c, took);
				if (took) break;
			end
		end
		if (last) begin
			v.ok = !bad && ph == PH_TRAIL && seen == 2'b11 && vmin <= vmax;
			v.lo = v.ok ? vmin : 64'd0;
			v.hi = v.ok ? vmax : 64'd0;
			verdict_q.push_back(v);
			clear_parser();
		end
	endtask

	// predict on accepted bytes, compare accepted verdict words
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			clear_parser();
			verdict_q.delete();
			fail_count <= 0;
			verdicts_seen <= 0;
			accepts_seen <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				verdicts_seen <= verdicts_seen + 1;
				if (verdict_q.size() == 0) begin
					$error("verdict word with none expected: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = verdict_q.pop_front();
					if (want.ok) accepts_seen <= accepts_seen + 1;
					if (m_tdata[0] !== want.ok || m_tdata[64:1] !== want.lo ||
						m_tdata[128:65] !== want.hi || m_tdata[OUT_W-1:129] !== '0) begin
						if (m_tdata[0] !== want.ok)
							$error("accepted: expected %0d, got %0d", want.ok, m_tdata[0]);
						if (m_tdata[64:1] !== want.lo)
							$error("lowest version: expected %0d, got %0d", want.lo,
								m_tdata[64:1]);
						if (m_tdata[128:65] !== want.hi)
							$error("highest version: expected %0d, got %0d", want.hi,
								m_tdata[128:65]);
						if (m_tdata[OUT_W-1:129] !== '0)
							$error("padding: expected 0, got %h", m_tdata[OUT_W-1:129]);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
			pending <= verdict_q.size();
		end
	end
endmodule

>>> sim/json_hello_version_checker_unit_test.sv
`timescale 1ns / 1ps

module json_hello_version_checker_unit_test;
	import jhv_pkg::*;

	localparam int LIMIT = 400000;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // [7:0] data_byte
	logic                s_tlast;   // last_byte
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;   // [0] accepted, [64:1] min, [128:65] max
	int                  fail_count;
	int                  pending;
	int                  verdicts_seen;
	int                  accepts_seen;
	int                  cycles;
	int                  bytes_sent;
	logic                hold_rx;

	json_hello_version_checker_unit dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata
	);

	jhv_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .fail_count, .pending,
		.verdicts_seen, .accepts_seen
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rx) m_tready <= 1'b0;
			else if ($urandom_range(0, 99) < 8) m_tready <= 1'b0;
			else if ($urandom_range(0, 199) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
				m_tready <= 1'b1;
			end else m_tready <= 1'b1;
		end
	end

	function automatic string rand_ws();
		string s;
		byte w[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		s = "";
		repeat ($urandom_range(0, 2)) s = {s, string'(w[$urandom_range(0, 5)])};
		return s;
	endfunction

	function automatic string rand_dec(bit huge);
		string s;
		longint unsigned v;
		case ($urandom_range(0, 5))
			0: v = 64'hFFFF_FFFF_FFFF_FFFF;
			1: v = 0;
			2: v = {$urandom, $urandom};
			default: v = $urandom_range(0, 40);
		endcase
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 7) == 0) s = {"00", s};
		if (huge) s = "18446744073709551616";
		return s;
	endfunction

	// any JSON value, depth-bounded
	function automatic string rand_value(int depth);
		string s;
		int n;
		if (depth >= 3) n = $urandom_range(0, 4); else n = $urandom_range(0, 6);
		case (n)
			0: return "true";
			1: return ($urandom_range(0, 1)) ? "false" : "null";
			2: return "-12.5e+3";
			3: return ($urandom_range(0, 1)) ? "0" : "7E9";
			4: return "\"a\\n\\u00fF\xc3\"";
			5: begin
				s = "[";
				repeat ($urandom_range(0, 2)) s = {s, rand_value(depth + 1), ","};
				if (s.len() > 1 && $urandom_range(0, 1)) s = s.substr(0, s.len() - 2);
				else s = {s, rand_value(depth + 1)};
				return {s, "]"};
			end
			default: begin
				if ($urandom_range(0, 2) == 0) return "{ }";
				return {"{\"k\\\"\":", rand_ws(), rand_value(depth + 1), ",\"q\":1}"};
			end
		endcase
	endfunction

	function automatic string nest(int n);
		string s;
		s = "1";
		repeat (n) s = {"[", s, "]"};
		return s;
	endfunction

	// mostly well-formed hello messages, some damaged
	function automatic string rand_msg();
		string s, a, b, key_a;
		int r;
		r = $urandom_range(0, 9);
		key_a = ($urandom_range(0, 4) == 0) ? "min\\u0056ersion" : "minVersion";
		a = {"\"", key_a, "\":", rand_ws(), rand_dec($urandom_range(0, 30) == 0)};
		b = {"\"maxVersion\"", rand_ws(), ":", rand_dec(0)};
		s = {rand_ws(), "{", rand_ws()};
		if ($urandom_range(0, 1)) s = {s, "\"x\":", rand_value(0), ","};
		s = ($urandom_range(0, 1)) ? {s, a, ",", b} : {s, b, rand_ws(), ",", a};
		if ($urandom_range(0, 2) == 0) s = {s, ",\"zz\":", rand_value(0)};
		if (r == 0) s = {s, ",", a};
		s = {s, rand_ws(), "}", rand_ws()};
		if (r == 1) s[$urandom_range(0, s.len() - 1)] = byte'($urandom_range(0, 255));
		if (r == 2) s = s.substr(0, $urandom_range(0, s.len() - 1));
		return s;
	endfunction

	// send one message with random source gaps
	task automatic send_msg(string s);
		for (int i = 0; i < s.len(); i++) begin
			if ($urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= s[i];
			s_tlast  <= (i == s.len() - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			bytes_sent++;
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
	endtask

	initial begin
		string dir[$];
		string s;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		hold_rx  = 1'b0;
		bytes_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases
		dir.push_back("{\"minVersion\":0,\"maxVersion\":18446744073709551615}");
		dir.push_back("{\"maxVersion\":2,\"minVersion\":3}");
		dir.push_back("{}");
		dir.push_back("{\"minVersion\":1,\"minVersion\":1,\"maxVersion\":1}");
		dir.push_back("{\"minVersion\":-1,\"maxVersion\":1}");
		dir.push_back("{\"minVersion\":1.0,\"maxVersion\":2}");
		dir.push_back({"{\"a\":", nest(16), ",\"minVersion\":1,\"maxVersion\":1}"});
		dir.push_back({"{\"a\":", nest(15), ",\"minVersion\":1,\"maxVersion\":1}"});
		dir.push_back("{\"m\\u0069nVersion\":5,\"maxVersion\":5} \x0d");
		dir.push_back("{\"minVersion\":1,\"maxVersion\":2");
		dir.push_back("{\"s\":\"\x01\",\"minVersion\":1,\"maxVersion\":2}");
		dir.push_back("\xff\x80\x7f");
		foreach (dir[i]) send_msg(dir[i]);

		// long receiver hold-off while the source keeps offering
		fork
			begin
				hold_rx = 1'b1;
				repeat (150) @(posedge clk);
				hold_rx = 1'b0;
			end
			repeat (8) send_msg("{\"minVersion\":1,\"maxVersion\":9}");
		join

		// pause the source until everything has drained
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		while (bytes_sent < 1350) send_msg(rand_msg());

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d bytes sent, %0d verdicts checked, %0d of them accepts",
			bytes_sent, verdicts_seen, accepts_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
